// ===== rtl/fis_pkg.sv =====
// Shared types and constants for the frame interval statistics block.
package fis_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned DT_BITS_DEF    = 24;

  localparam logic [31:0] WINDOW_US_RESET = 32'd1000000;
  // frames per second in Q8 = count * 1e6 * 256 / elapsed_us
  localparam logic [63:0] FPS_SCALE       = 64'd256000000;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

// ===== rtl/fis_if.sv =====
// Channel interfaces: timestamp input and statistics result.
interface fis_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_us;

  modport source (output valid, output time_us, input ready);
  modport sink   (input valid, input time_us, output ready);
endinterface

interface fis_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] dt_us;
  logic        dt_valid;
  logic        report;
  logic [15:0] interval_cnt;
  logic [31:0] elapsed_us;
  logic [31:0] fps_q8;
  logic [31:0] mean_q8;
  logic [31:0] stddev_q8;
  logic [23:0] min_dt_us;
  logic [23:0] max_dt_us;

  modport source (output valid, output dt_us, output dt_valid, output report,
                  output interval_cnt, output elapsed_us, output fps_q8, output mean_q8,
                  output stddev_q8, output min_dt_us, output max_dt_us, input ready);
  modport sink   (input valid, input dt_us, input dt_valid, input report,
                  input interval_cnt, input elapsed_us, input fps_q8, input mean_q8,
                  input stddev_q8, input min_dt_us, input max_dt_us, output ready);
endinterface

// ===== rtl/fis_alu.sv =====
// Shared serial unit: saturating multiply, restoring divide, integer square root.
module fis_alu import fis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alu_cmd_t    cmd_i,
  input  logic [63:0] opa_i,
  input  logic [63:0] opb_i,
  output alu_sts_t    sts_o,
  output logic [63:0] res_o
);

  alu_op_e     op_q;
  logic [63:0] x_q, x_d;
  logic [63:0] y_q, y_d;
  logic [63:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;

  logic [64:0] rem_sh, rem_sub, mul_sum;
  logic [63:0] sq_trial;

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    rem_sh  = {acc_q, x_q[63]};
    rem_sub = rem_sh - {1'b0, y_q};
    mul_sum = {1'b0, acc_q[62:0], 1'b0} + {1'b0, (y_q[63] ? x_q : 64'd0)};
    sq_trial = acc_q + y_q;
    case (op_q)
      ALU_DIV: begin
        if (rem_sh >= {1'b0, y_q}) begin
          acc_d = rem_sub[63:0];
          x_d   = {x_q[62:0], 1'b1};
        end else begin
          acc_d = rem_sh[63:0];
          x_d   = {x_q[62:0], 1'b0};
        end
      end
      ALU_MUL: begin
        // MSB first; overflow beyond 64 bits is sticky
        ovf_d = ovf_q | acc_q[63] | mul_sum[64];
        acc_d = mul_sum[63:0];
        y_d   = {y_q[62:0], 1'b0};
      end
      ALU_SQRT: begin
        if (x_q >= sq_trial) begin
          x_d   = x_q - sq_trial;
          acc_d = {1'b0, acc_q[63:1]} + y_q;
        end else begin
          acc_d = {1'b0, acc_q[63:1]};
        end
        y_d = {2'b00, y_q[63:2]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= ALU_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        op_q   <= cmd_i.op;
        busy_q <= 1'b1;
        x_q    <= opa_i;
        acc_q  <= '0;
        ovf_q  <= 1'b0;
        if (cmd_i.op == ALU_SQRT) begin
          y_q   <= 64'd1 << 62;
          cnt_q <= 7'd31;
        end else begin
          y_q   <= opb_i;
          cnt_q <= 7'd63;
        end
      end else if (busy_q) begin
        x_q   <= x_d;
        y_q   <= y_d;
        acc_q <= acc_d;
        ovf_q <= ovf_d;
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (op_q)
      ALU_DIV:  res_o = x_q;
      ALU_MUL:  res_o = ovf_q ? '1 : acc_q;
      ALU_SQRT: res_o = acc_q;
      default:  res_o = acc_q;
    endcase
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q) else $error("alu started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("alu done without a run");
  a_sqrt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == ALU_SQRT) |-> cnt_q < 7'd32) else $error("sqrt step count");

endmodule

// ===== rtl/frame_interval_statistics_top.sv =====
// Frame interval statistics: each timestamp transaction yields one result with the
// interval since the previous frame (none on the first); when the window time reaches
// window_us or the interval count saturates, the result also carries count, elapsed
// time, FPS, Welford mean, sample standard deviation, min and max (all Q8 where noted)
// and the window restarts. Multiplies, divides and the square root run through one serial
// unit one bit per cycle: a non-reporting item takes a 64-step divide for the mean and a
// 64-step multiply for M2, a reporting item also an FPS multiply and divide, a variance
// divide and a 32-step square root. The input is not ready while an item is in work.
module frame_interval_statistics_top import fis_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned DT_BITS    = DT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  fis_in_if.sink      in_i,
  fis_out_if.source   out_o
);

  localparam int unsigned MW = DT_BITS + 8;
  localparam int unsigned DW = MW + 1;
  localparam logic [31:0] DT_MAX32 = 32'((64'd1 << DT_BITS) - 64'd1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MEAN = 9'b000000010,
    S_M2   = 9'b000000100,
    S_FMUL = 9'b000001000,
    S_FDIV = 9'b000010000,
    S_VAR  = 9'b000100000,
    S_VDIV = 9'b001000000,
    S_SQRT = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q;

  logic [31:0]           window_us_q;
  logic [31:0]           last_q, wstart_q, time_q, elapsed_q;
  logic                  have_ref_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [MW-1:0]         mean_q, dtq_q, adelta_q;
  logic                  dneg_q;
  logic [63:0]           m2_q;
  logic [DT_BITS-1:0]    min_q, max_q, dt_q;
  logic                  dtv_q, rep_q;
  logic [31:0]           fps_q, sd_q;

  alu_cmd_t    cmd_q;
  logic [63:0] opa_q, opb_q, res;
  alu_sts_t    sts;

  logic                  out_v_q;
  logic [23:0]           o_dt_q, o_min_q, o_max_q;
  logic                  o_dtv_q, o_rep_q;
  logic [15:0]           o_cnt_q;
  logic [31:0]           o_el_q, o_fps_q, o_mean_q, o_sd_q;

  fis_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_q),
    .opa_i  (opa_q),
    .opb_i  (opb_q),
    .sts_o  (sts),
    .res_o  (res)
  );

  // accept-time arithmetic
  logic                  in_acc;
  logic [31:0]           diff, dt32;
  logic [DT_BITS-1:0]    dt;
  logic [COUNT_BITS-1:0] n_new;
  logic [MW-1:0]         dtq;
  logic [DW-1:0]         delta, adelta_w;
  logic [31:0]           el_new;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign diff     = in_i.time_us - last_q;
  assign dt32     = (diff > DT_MAX32) ? DT_MAX32 : diff;
  assign dt       = dt32[DT_BITS-1:0];
  assign n_new    = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;
  assign dtq      = {dt, 8'd0};
  assign delta    = {1'b0, dtq} - {1'b0, mean_q};
  assign adelta_w = delta[DW-1] ? -delta : delta;
  assign el_new   = in_i.time_us - wstart_q;

  // mean update from quotient
  logic [DW-1:0] qs, mean_new, delta2, adelta2;
  assign qs       = dneg_q ? -{1'b0, res[MW-1:0]} : {1'b0, res[MW-1:0]};
  assign mean_new = {1'b0, mean_q} + qs;
  assign delta2   = {1'b0, dtq_q} - mean_new;
  assign adelta2  = delta2[DW-1] ? -delta2 : delta2;

  logic [64:0] m2_sum;
  assign m2_sum = {1'b0, m2_q} + {9'd0, res[63:8]};

  logic [63:0] cnt64, mean64, dt64, min64, max64;
  assign cnt64  = 64'(count_q);
  assign mean64 = 64'(mean_q);
  assign dt64   = 64'(dt_q);
  assign min64  = 64'(min_q);
  assign max64  = 64'(max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_us_q <= WINDOW_US_RESET;
      last_q      <= '0;
      wstart_q    <= '0;
      time_q      <= '0;
      elapsed_q   <= '0;
      have_ref_q  <= 1'b0;
      count_q     <= '0;
      mean_q      <= '0;
      dtq_q       <= '0;
      adelta_q    <= '0;
      dneg_q      <= 1'b0;
      m2_q        <= '0;
      min_q       <= '1;
      max_q       <= '0;
      dt_q        <= '0;
      dtv_q       <= 1'b0;
      rep_q       <= 1'b0;
      fps_q       <= '0;
      sd_q        <= '0;
      cmd_q       <= '{start: 1'b0, op: ALU_MUL};
      opa_q       <= '0;
      opb_q       <= '0;
      out_v_q     <= 1'b0;
      o_dt_q      <= '0;
      o_dtv_q     <= 1'b0;
      o_rep_q     <= 1'b0;
      o_cnt_q     <= '0;
      o_el_q      <= '0;
      o_fps_q     <= '0;
      o_mean_q    <= '0;
      o_sd_q      <= '0;
      o_min_q     <= '0;
      o_max_q     <= '0;
    end else begin
      cmd_q.start <= 1'b0;
      if (cfg_we_i) begin
        window_us_q <= cfg_wdata_i;
      end
      if (out_v_q && out_o.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            time_q <= in_i.time_us;
            last_q <= in_i.time_us;
            if (!have_ref_q) begin
              have_ref_q <= 1'b1;
              wstart_q   <= in_i.time_us;
              dt_q       <= '0;
              dtv_q      <= 1'b0;
              rep_q      <= 1'b0;
              state_q    <= S_DONE;
            end else begin
              dt_q      <= dt;
              dtv_q     <= 1'b1;
              count_q   <= n_new;
              elapsed_q <= el_new;
              rep_q     <= (el_new >= window_us_q) || (n_new == COUNT_MAX);
              dtq_q     <= dtq;
              dneg_q    <= delta[DW-1];
              adelta_q  <= adelta_w[MW-1:0];
              if (dt < min_q) min_q <= dt;
              if (dt > max_q) max_q <= dt;
              cmd_q     <= '{start: 1'b1, op: ALU_DIV};
              opa_q     <= 64'(adelta_w[MW-1:0]);
              opb_q     <= 64'(n_new);
              state_q   <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (sts.done) begin
            mean_q  <= mean_new[MW-1:0];
            cmd_q   <= '{start: 1'b1, op: ALU_MUL};
            opa_q   <= 64'(adelta_q);
            opb_q   <= 64'(adelta2[MW-1:0]);
            state_q <= S_M2;
          end
        end
        S_M2: begin
          if (sts.done) begin
            m2_q <= m2_sum[64] ? '1 : m2_sum[63:0];
            if (rep_q) begin
              cmd_q   <= '{start: 1'b1, op: ALU_MUL};
              opa_q   <= cnt64;
              opb_q   <= FPS_SCALE;
              state_q <= S_FMUL;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_FMUL: begin
          if (sts.done) begin
            if (elapsed_q == '0) begin
              fps_q   <= '1;
              state_q <= S_VAR;
            end else begin
              cmd_q   <= '{start: 1'b1, op: ALU_DIV};
              opa_q   <= res;
              opb_q   <= 64'(elapsed_q);
              state_q <= S_FDIV;
            end
          end
        end
        S_FDIV: begin
          if (sts.done) begin
            fps_q   <= (res[63:32] != '0) ? '1 : res[31:0];
            state_q <= S_VAR;
          end
        end
        S_VAR: begin
          if (count_q > COUNT_BITS'(1)) begin
            cmd_q   <= '{start: 1'b1, op: ALU_DIV};
            opa_q   <= m2_q;
            opb_q   <= cnt64 - 64'd1;
            state_q <= S_VDIV;
          end else begin
            sd_q    <= '0;
            state_q <= S_DONE;
          end
        end
        S_VDIV: begin
          if (sts.done) begin
            cmd_q   <= '{start: 1'b1, op: ALU_SQRT};
            opa_q   <= (res[63:56] != '0) ? '1 : {res[55:0], 8'd0};
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sts.done) begin
            sd_q    <= res[31:0];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_v_q || out_o.ready) begin
            out_v_q  <= 1'b1;
            o_dt_q   <= dt64[23:0];
            o_dtv_q  <= dtv_q;
            o_rep_q  <= rep_q;
            if (rep_q) begin
              o_cnt_q  <= cnt64[15:0];
              o_el_q   <= elapsed_q;
              o_fps_q  <= fps_q;
              o_mean_q <= (mean64[63:32] != '0) ? '1 : mean64[31:0];
              o_sd_q   <= sd_q;
              o_min_q  <= min64[23:0];
              o_max_q  <= max64[23:0];
              wstart_q <= time_q;
              count_q  <= '0;
              mean_q   <= '0;
              m2_q     <= '0;
              min_q    <= '1;
              max_q    <= '0;
            end else begin
              o_cnt_q  <= '0;
              o_el_q   <= '0;
              o_fps_q  <= '0;
              o_mean_q <= '0;
              o_sd_q   <= '0;
              o_min_q  <= '0;
              o_max_q  <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.dt_us        = o_dt_q;
  assign out_o.dt_valid     = o_dtv_q;
  assign out_o.report       = o_rep_q;
  assign out_o.interval_cnt = o_cnt_q;
  assign out_o.elapsed_us   = o_el_q;
  assign out_o.fps_q8       = o_fps_q;
  assign out_o.mean_q8      = o_mean_q;
  assign out_o.stddev_q8    = o_sd_q;
  assign out_o.min_dt_us    = o_min_q;
  assign out_o.max_dt_us    = o_max_q;

  a_alu_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.busy || cmd_q.start) |-> state_q != S_IDLE) else $error("alu active in idle");
  a_report_has_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && o_rep_q) |-> o_dtv_q) else $error("report without interval");
  a_first_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !dtv_q) |-> !rep_q) else $error("report on first item");
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && rep_q && (!out_v_q || out_o.ready)) |=> count_q == '0)
    else $error("window not cleared");

endmodule

// ===== test/frame_interval_statistics_top_test.sv =====
// Self-checking testbench for frame_interval_statistics_top: queue-fed driver, clocked monitor.
module frame_interval_statistics_top_test;
  import fis_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned DRAIN_CYCLES = 500;
  localparam logic [63:0] DT_LIMIT = 64'hFF_FFFF;
  localparam logic [63:0] COUNT_LIMIT = 64'hFFFF;
  localparam logic [63:0] ALL_ONES32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [23:0] dt_us;
    logic        dt_valid;
    logic        report;
    logic [15:0] interval_cnt;
    logic [31:0] elapsed_us;
    logic [31:0] fps_q8;
    logic [31:0] mean_q8;
    logic [31:0] stddev_q8;
    logic [23:0] min_dt_us;
    logic [23:0] max_dt_us;
  } interval_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  fis_in_if  in_if();
  fis_out_if out_if();

  frame_interval_statistics_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    in_if.valid   = 1'b0;
    in_if.time_us = '0;
    out_if.ready  = 1'b0;
  end

  // Stimulus and scoreboard state
  logic [31:0]      pending_times[$];
  interval_result_t expected_results[$];
  bit               idle_en = 1'b1;
  bit               tx_pause = 1'b0;
  bit               rx_hold = 1'b0;
  bit               rx_hold_req = 1'b0;
  int unsigned      tx_gap = 0;
  int unsigned      rx_stall = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  // Predictor state
  logic [31:0] win_len;
  logic [31:0] prev_time;
  logic [31:0] win_start;
  bit          have_ref;
  logic [63:0] n_intervals;
  logic [63:0] mean_q8_acc;
  logic [63:0] m2_acc;
  logic [63:0] dt_min;
  logic [63:0] dt_max;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function void clear_window();
    n_intervals = '0;
    mean_q8_acc = '0;
    m2_acc      = '0;
    dt_min      = DT_LIMIT;
    dt_max      = '0;
  endfunction

  function void reset_predictor();
    win_len   = WINDOW_US_RESET;
    prev_time = '0;
    win_start = '0;
    have_ref  = 1'b0;
    clear_window();
  endfunction

  // Welford update for one timestamp; pushes the expected result.
  function void predict_interval(input logic [31:0] t);
    interval_result_t r;
    logic [63:0]  dt, n, a, b, inc, fps, variance, v16, sd;
    logic [127:0] prod;
    logic [31:0]  elapsed;
    longint       dtq, m_old, delta, m_new, delta2;
    r = '0;
    if (!have_ref) begin
      have_ref  = 1'b1;
      prev_time = t;
      win_start = t;
      expected_results.push_back(r);
      return;
    end
    dt = {32'd0, t - prev_time};
    if (dt > DT_LIMIT) dt = DT_LIMIT;
    prev_time = t;
    n = n_intervals + 1;
    if (n > COUNT_LIMIT) n = COUNT_LIMIT;
    n_intervals = n;

    dtq    = longint'(dt << 8);
    m_old  = longint'(mean_q8_acc);
    delta  = dtq - m_old;
    m_new  = m_old + delta / longint'(n);
    delta2 = dtq - m_new;
    mean_q8_acc = m_new;

    a    = (delta < 0) ? -delta : delta;
    b    = (delta2 < 0) ? -delta2 : delta2;
    prod = a * b;
    inc  = (prod[127:64] != 0) ? '1 : prod[63:0];
    inc  = inc >> 8;
    m2_acc = (m2_acc > ~inc) ? '1 : m2_acc + inc;

    if (dt < dt_min) dt_min = dt;
    if (dt > dt_max) dt_max = dt;

    elapsed    = t - win_start;
    r.dt_us    = dt[23:0];
    r.dt_valid = 1'b1;

    if (elapsed >= win_len || n >= COUNT_LIMIT) begin
      sd = '0;
      if (elapsed == 0) begin
        fps = ALL_ONES32;
      end else begin
        fps = (n * FPS_SCALE) / {32'd0, elapsed};
        if (fps > ALL_ONES32) fps = ALL_ONES32;
      end
      if (n >= 2) begin
        variance = m2_acc / (n - 1);
        v16 = (variance > ({64{1'b1}} >> 8)) ? '1 : (variance << 8);
        sd = floor_sqrt(v16);
        if (sd > ALL_ONES32) sd = ALL_ONES32;
      end
      r.report       = 1'b1;
      r.interval_cnt = n[15:0];
      r.elapsed_us   = elapsed;
      r.fps_q8       = fps[31:0];
      r.mean_q8      = (mean_q8_acc > ALL_ONES32) ? 32'hFFFF_FFFF : mean_q8_acc[31:0];
      r.stddev_q8    = sd[31:0];
      r.min_dt_us    = dt_min[23:0];
      r.max_dt_us    = dt_max[23:0];
      win_start = t;
      clear_window();
    end
    expected_results.push_back(r);
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %0h got %0h", name, want, got);
    end
  endfunction

  // Driver: one transaction per handshake, fed from pending_times.
  always @(posedge clk_i) begin
    bit next_valid;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) predict_interval(in_if.time_us);
      if (!(in_if.valid && !in_if.ready)) begin
        next_valid = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!tx_pause && pending_times.size() > 0) begin
          next_valid = 1'b1;
          in_if.time_us <= pending_times.pop_front();
          if (idle_en && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 6);
        end
        in_if.valid <= next_valid;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    interval_result_t got, want;
    bit next_ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.dt_us, out_if.dt_valid, out_if.report, out_if.interval_cnt,
                out_if.elapsed_us, out_if.fps_q8, out_if.mean_q8, out_if.stddev_q8,
                out_if.min_dt_us, out_if.max_dt_us};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          check_field("dt_us", want.dt_us, got.dt_us);
          check_field("dt_valid", want.dt_valid, got.dt_valid);
          check_field("report", want.report, got.report);
          check_field("interval_cnt", want.interval_cnt, got.interval_cnt);
          check_field("elapsed_us", want.elapsed_us, got.elapsed_us);
          check_field("fps_q8", want.fps_q8, got.fps_q8);
          check_field("mean_q8", want.mean_q8, got.mean_q8);
          check_field("stddev_q8", want.stddev_q8, got.stddev_q8);
          check_field("min_dt_us", want.min_dt_us, got.min_dt_us);
          check_field("max_dt_us", want.max_dt_us, got.max_dt_us);
        end
      end
      next_ready = 1'b0;
      if (rx_hold) begin
        next_ready = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end else begin
        next_ready = 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 6);
      end
      out_if.ready <= next_ready;
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    wait (rx_hold_req);
    rx_hold = 1'b1;
    repeat (3000) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_times.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [31:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_len = value;
  endtask

  // Random timestamps: mostly short steps, now and then a jump anywhere.
  task automatic push_random(inout logic [31:0] now, input int unsigned count,
                             input int unsigned max_step);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) now = $urandom();
      else now = now + $urandom_range(0, max_step);
      pending_times.push_back(now);
    end
  endtask

  initial begin
    logic [31:0] now;
    reset_predictor();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reference, zero interval, backwards step, oversize interval, window close
    now = 32'd100;
    pending_times.push_back(now);
    pending_times.push_back(now);
    pending_times.push_back(now + 32'd5000);
    pending_times.push_back(now + 32'd3900);
    now = now + 32'd3900 + 32'h0100_0005;
    pending_times.push_back(now);
    pending_times.push_back(now + 32'd1000);
    pending_times.push_back(now + 32'd1000000);
    // alternating zero and saturated intervals push M2 toward saturation
    now = now + 32'd1000000;
    for (int k = 0; k < 6; k++) begin
      pending_times.push_back(now);
      now = now + 32'h00FF_FFFF;
      pending_times.push_back(now);
    end

    // window of zero: every item reports, zero elapsed gives all-ones fps
    write_window(32'd0);
    pending_times.push_back(now);
    pending_times.push_back(now);
    pending_times.push_back(now + 32'd7);

    // largest window: only a full wrap closes it
    write_window(32'hFFFF_FFFF);
    now = 32'hFFFF_FFF0;
    pending_times.push_back(now + 32'd7);
    pending_times.push_back(now);
    pending_times.push_back(32'h0000_0010);
    pending_times.push_back(now + 32'd6);

    write_window(32'd1);
    now = $urandom();
    push_random(now, 200, 50);

    write_window(32'd20000);
    push_random(now, 400, 3000);
    rx_hold_req = 1'b1;

    write_window($urandom_range(2000, 200000));
    push_random(now, 150, 8000);
    while (pending_times.size() > 75) @(posedge clk_i);
    tx_pause = 1'b1;
    while (in_if.valid || expected_results.size() != 0) @(posedge clk_i);
    tx_pause = 1'b0;
    push_random(now, 150, 8000);

    write_window(32'hFFFF_FFFF);
    push_random(now, 100, 4000);

    write_window(32'd1000000);
    push_random(now, 250, 60000);
    while (pending_times.size() > 150) @(posedge clk_i);
    idle_en = 1'b0;

    while (pending_times.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
